### src/fra_pkg.sv
// Shared types, constants and codes of the frequency residency accumulator.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package fra_pkg;

	// Table geometry.
	localparam int MAX_ENTRIES = 16;
	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;

	// Field widths.
	localparam int FREQ_W  = 32;
	localparam int TIME_W  = 32;
	localparam int CYCLE_W = 16;
	localparam int ACC_W   = 48;
	localparam int US_PER_MS = 1000;
	// Widest cycle length in microseconds needs this many bits.
	localparam int SPAN_W = $clog2(65535 * US_PER_MS + 1);
	localparam int PROD_W = TIME_W + SPAN_W;
	localparam int STEP_W = $clog2(SPAN_W + 1);

	// Configuration register indexes.
	localparam logic [0:0] REG_ENABLE     = 1'b0;
	localparam logic [0:0] REG_TABLE_SIZE = 1'b1;

	typedef enum logic [1:0] {
		OP_UPDATE = 2'd0,
		OP_READ   = 2'd1,
		OP_CLEAR  = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_IGNORED   = 3'd1,
		ST_FULL      = 3'd2,
		ST_DISABLED  = 3'd3,
		ST_BAD_INDEX = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,
		S_CMP,
		S_WAIT,
		S_RDOUT
	} fra_state_t;

	typedef enum logic [1:0] {
		DV_IDLE,
		DV_SPAN,
		DV_MUL,
		DV_ITER
	} div_state_t;

	typedef struct packed {
		logic [FREQ_W-1:0] freq;
		logic [ACC_W-1:0]  run;
		logic [ACC_W-1:0]  idle;
	} entry_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
	} tbl_rd_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		entry_t           data;
	} tbl_wr_t;

endpackage

`default_nettype wire

### src/fra_table.sv
// Entry store: one synchronous memory holding frequency and both accumulators.
// Depends on fra_pkg for the entry and access types.
`default_nettype none

module fra_table (
	input  wire logic           clk,
	input  wire fra_pkg::tbl_rd_t rd,
	input  wire fra_pkg::tbl_wr_t wr,
	output fra_pkg::entry_t     rdata
);
	import fra_pkg::*;

	entry_t mem [MAX_ENTRIES];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd.en) begin
			rdata_q <= mem[rd.addr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

### src/fra_divider.sv
// Run and idle time unit: span multiply, product multiply, then a restoring
// divide that yields one quotient bit a cycle. Depends on fra_pkg.
`default_nettype none

module fra_divider (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [fra_pkg::TIME_W-1:0]  busy_ticks,
	input  wire logic [fra_pkg::TIME_W-1:0]  total_ticks,
	input  wire logic [fra_pkg::CYCLE_W-1:0] cycle_length_ms,
	output logic                             done,
	output logic [fra_pkg::SPAN_W-1:0]       run_us,
	output logic [fra_pkg::SPAN_W-1:0]       idle_us
);
	import fra_pkg::*;

	div_state_t state_q, state_d;
	logic              done_q;
	logic [TIME_W-1:0]  busy_q, total_q, rem_q;
	logic [CYCLE_W-1:0] cycle_q;
	logic [SPAN_W-1:0]  span_q, low_q, quot_q;
	logic [STEP_W-1:0]  step_q;
	logic [PROD_W-1:0]  prod;
	logic [TIME_W:0]    trial;
	logic               take;
	logic               last_step;

	assign prod      = PROD_W'(busy_q) * PROD_W'(span_q);
	assign trial     = {rem_q, low_q[SPAN_W-1]};
	assign take      = trial >= {1'b0, total_q};
	assign last_step = step_q == STEP_W'(SPAN_W - 1);

	always_comb begin
		state_d = state_q;
		case (state_q)
			DV_IDLE: if (start) state_d = DV_SPAN;
			DV_SPAN: state_d = DV_MUL;
			DV_MUL:  state_d = (busy_q >= total_q) ? DV_IDLE : DV_ITER;
			DV_ITER: if (last_step) state_d = DV_IDLE;
			default: state_d = DV_IDLE;
		endcase
		// A new start always restarts the unit.
		if (start) begin
			state_d = DV_SPAN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DV_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (start) begin
				done_q <= 1'b0;
			end else if ((state_q == DV_MUL && busy_q >= total_q) ||
			             (state_q == DV_ITER && last_step)) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			busy_q  <= busy_ticks;
			total_q <= total_ticks;
			cycle_q <= cycle_length_ms;
		end
		case (state_q)
			DV_SPAN: span_q <= SPAN_W'(32'(cycle_q) * 32'(US_PER_MS));
			DV_MUL: begin
				// Busy at or above total clamps the run time to the whole span.
				if (busy_q >= total_q) begin
					quot_q <= span_q;
				end else begin
					rem_q  <= prod[PROD_W-1:SPAN_W];
					low_q  <= prod[SPAN_W-1:0];
					quot_q <= '0;
					step_q <= '0;
				end
			end
			DV_ITER: begin
				rem_q  <= take ? TIME_W'(trial - {1'b0, total_q}) : trial[TIME_W-1:0];
				low_q  <= {low_q[SPAN_W-2:0], 1'b0};
				quot_q <= {quot_q[SPAN_W-2:0], take};
				step_q <= STEP_W'(step_q + 1'b1);
			end
			default: ;
		endcase
	end

	assign done    = done_q;
	assign run_us  = quot_q;
	assign idle_us = span_q - quot_q;

endmodule

`default_nettype wire

### src/freq_residency_accumulator_unit.sv
// Top level of the frequency residency accumulator: sequencer, configuration
// and result registers. Depends on fra_pkg, fra_table and fra_divider.
//
//   channel   ports                                         handshake
//   ------    -----------------------------------------    ------------------------
//   item in   operation frequency busy_ticks total_ticks    start & !busy
//             cycle_length_ms read_index
//   result    status entry_frequency entry_run_time         done, one cycle
//             entry_idle_time entries_filled
//   config    register_index write_data                     write_enable
//
// For a clear, an ignored sample or a rejected or unfilled read, the result
// appears the cycle after the item is taken. A read of a filled entry first
// passes through the table memory's registered read port and the S_RDOUT state.
// An update takes the longer of two overlapped activities: the entry search,
// a read and a compare per searched entry through the single memory read port,
// and the time unit, span and product multiply steps plus up to 26 divide steps.
// Reset clears the fill count, so the table reads as empty at once; no clearing
// sweep is needed since entries at or above the fill count are never read.
// The receiver cannot stall; each result is held until the next result.
`default_nettype none

module freq_residency_accumulator_unit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic [1:0]                  operation,
	input  wire logic [fra_pkg::FREQ_W-1:0]  frequency,
	input  wire logic [fra_pkg::TIME_W-1:0]  busy_ticks,
	input  wire logic [fra_pkg::TIME_W-1:0]  total_ticks,
	input  wire logic [fra_pkg::CYCLE_W-1:0] cycle_length_ms,
	input  wire logic [3:0]                  read_index,
	input  wire logic                        write_enable,
	input  wire logic [0:0]                  register_index,
	input  wire logic [4:0]                  write_data,
	output logic                             done,
	output logic [2:0]                       status,
	output logic [fra_pkg::FREQ_W-1:0]       entry_frequency,
	output logic [fra_pkg::ACC_W-1:0]        entry_run_time,
	output logic [fra_pkg::ACC_W-1:0]        entry_idle_time,
	output logic [4:0]                       entries_filled
);
	import fra_pkg::*;

	// Saturating accumulate; the addend is far narrower than the accumulator,
	// so an overflow always shows up as a carry out.
	function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] acc,
	                                             input logic [SPAN_W-1:0] inc);
		logic [ACC_W:0] sum;
		sum = {1'b0, acc} + (ACC_W + 1)'(inc);
		return sum[ACC_W] ? {ACC_W{1'b1}} : sum[ACC_W-1:0];
	endfunction

	// Sequencer and configuration state.
	fra_state_t        state_q, state_d;
	logic              enable_q;
	logic [4:0]        size_q;
	logic [CNT_W-1:0]  fill_q, fill_d;
	logic [CMP_W-1:0]  idx_q, idx_d;
	logic [IDX_W-1:0]  hit_q, hit_d;
	entry_t            entry_q, entry_d;
	logic [FREQ_W-1:0] freq_q;

	// Result registers.
	logic              done_q;
	status_t           status_q;
	logic [FREQ_W-1:0] efreq_q;
	logic [ACC_W-1:0]  erun_q, eidle_q;
	logic [4:0]        efill_q;

	// Result produced this cycle.
	logic              emit;
	status_t           emit_status;
	entry_t            emit_entry;

	// Table and time unit connections.
	tbl_rd_t           tbl_rd;
	tbl_wr_t           tbl_wr;
	entry_t            tbl_rdata;
	logic              div_start, div_done;
	logic [SPAN_W-1:0] run_us, idle_us;

	// Derived configuration values.
	logic [CMP_W-1:0]  size_ext, eff_size, fill_ext, limit, ridx_ext;
	logic              eff_en, accept, has_room;

	assign size_ext = CMP_W'(size_q);
	assign eff_size = (size_ext < CMP_W'(MAX_ENTRIES)) ? size_ext : CMP_W'(MAX_ENTRIES);
	assign eff_en   = enable_q && (eff_size != '0);
	assign fill_ext = CMP_W'(fill_q);
	assign has_room = fill_ext < eff_size;
	// Only entries below both the fill count and the active size are searched.
	assign limit    = has_room ? fill_ext : eff_size;
	assign ridx_ext = CMP_W'(read_index);
	assign accept   = start && (state_q == S_IDLE);

	fra_table u_table (
		.clk   (clk),
		.rd    (tbl_rd),
		.wr    (tbl_wr),
		.rdata (tbl_rdata)
	);

	fra_divider u_divider (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (div_start),
		.busy_ticks      (busy_ticks),
		.total_ticks     (total_ticks),
		.cycle_length_ms (cycle_length_ms),
		.done            (div_done),
		.run_us          (run_us),
		.idle_us         (idle_us)
	);

	always_comb begin
		state_d     = state_q;
		fill_d      = fill_q;
		idx_d       = idx_q;
		hit_d       = hit_q;
		entry_d     = entry_q;
		emit        = 1'b0;
		emit_status = ST_OK;
		emit_entry  = '0;
		tbl_rd      = '0;
		tbl_wr      = '0;
		div_start   = 1'b0;

		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (operation)
						OP_UPDATE: begin
							if (!eff_en || frequency == '0 || total_ticks == '0) begin
								emit        = 1'b1;
								emit_status = ST_IGNORED;
							end else begin
								// The time unit runs while the table is searched.
								div_start = 1'b1;
								idx_d     = '0;
								state_d   = S_RD;
							end
						end
						OP_READ: begin
							if (!eff_en) begin
								emit        = 1'b1;
								emit_status = ST_DISABLED;
							end else if (ridx_ext >= eff_size) begin
								emit        = 1'b1;
								emit_status = ST_BAD_INDEX;
							end else if (ridx_ext >= fill_ext) begin
								// An entry that was never filled reads as zeros.
								emit = 1'b1;
							end else begin
								tbl_rd.en   = 1'b1;
								tbl_rd.addr = ridx_ext[IDX_W-1:0];
								state_d     = S_RDOUT;
							end
						end
						OP_CLEAR: begin
							fill_d = '0;
							emit   = 1'b1;
						end
						default: begin
							emit        = 1'b1;
							emit_status = ST_IGNORED;
						end
					endcase
				end
			end
			S_RD: begin
				if (idx_q >= limit) begin
					if (has_room) begin
						// New frequency: claim the next free entry with empty totals.
						hit_d        = fill_q[IDX_W-1:0];
						entry_d      = '0;
						entry_d.freq = freq_q;
						fill_d       = CNT_W'(fill_q + 1'b1);
						state_d      = S_WAIT;
					end else begin
						emit        = 1'b1;
						emit_status = ST_FULL;
						state_d     = S_IDLE;
					end
				end else begin
					tbl_rd.en   = 1'b1;
					tbl_rd.addr = idx_q[IDX_W-1:0];
					state_d     = S_CMP;
				end
			end
			S_CMP: begin
				if (tbl_rdata.freq == freq_q) begin
					hit_d   = idx_q[IDX_W-1:0];
					entry_d = tbl_rdata;
					state_d = S_WAIT;
				end else begin
					idx_d   = CMP_W'(idx_q + 1'b1);
					state_d = S_RD;
				end
			end
			S_WAIT: begin
				if (div_done) begin
					tbl_wr.en        = 1'b1;
					tbl_wr.addr      = hit_q;
					tbl_wr.data.freq = entry_q.freq;
					tbl_wr.data.run  = sat_add(entry_q.run, run_us);
					tbl_wr.data.idle = sat_add(entry_q.idle, idle_us);
					emit             = 1'b1;
					emit_entry       = tbl_wr.data;
					state_d          = S_IDLE;
				end
			end
			S_RDOUT: begin
				emit       = 1'b1;
				emit_entry = tbl_rdata;
				state_d    = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			enable_q <= 1'b0;
			size_q   <= '0;
			fill_q   <= '0;
			done_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= emit;
			if (write_enable && register_index == REG_ENABLE && !write_data[0]) begin
				// Turning collection off empties the table.
				fill_q <= '0;
			end else begin
				fill_q <= fill_d;
			end
			if (write_enable) begin
				case (register_index)
					REG_ENABLE:     enable_q <= write_data[0];
					REG_TABLE_SIZE: size_q <= write_data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_q   <= idx_d;
		hit_q   <= hit_d;
		entry_q <= entry_d;
		if (accept) begin
			freq_q <= frequency;
		end
		if (emit) begin
			status_q <= emit_status;
			efreq_q  <= emit_entry.freq;
			erun_q   <= emit_entry.run;
			eidle_q  <= emit_entry.idle;
			efill_q  <= 5'(fill_d);
		end
	end

	assign busy            = state_q != S_IDLE;
	assign done            = done_q;
	assign status          = status_q;
	assign entry_frequency = efreq_q;
	assign entry_run_time  = erun_q;
	assign entry_idle_time = eidle_q;
	assign entries_filled  = efill_q;

	// The fill count never passes the table depth.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(MAX_ENTRIES))
		else $error("fill count beyond table depth");

	// A compare always sees the data of the read issued the cycle before.
	a_cmp_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CMP |-> $past(state_q) == S_RD)
		else $error("compare without a preceding table read");

	// The entry being updated is always one that is filled.
	a_hit_filled: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WAIT |-> CNT_W'(hit_q) < fill_q)
		else $error("update of an unfilled entry");

	// The table is written only when an update completes, and it then reports.
	a_write_emits: assert property (@(posedge clk) disable iff (!arst_n)
		tbl_wr.en |=> done && status == ST_OK && state_q == S_IDLE)
		else $error("table write without a matching result");

endmodule

`default_nettype wire

### test/fra_residency_checker.sv
// Checker for the frequency residency accumulator: mirrors the table and the
// configuration, predicts each result and compares it field by field.
// Depends on fra_pkg for field widths, operation and status codes.
module fra_residency_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        busy,
	input  logic [1:0]                  operation,
	input  logic [fra_pkg::FREQ_W-1:0]  frequency,
	input  logic [fra_pkg::TIME_W-1:0]  busy_ticks,
	input  logic [fra_pkg::TIME_W-1:0]  total_ticks,
	input  logic [fra_pkg::CYCLE_W-1:0] cycle_length_ms,
	input  logic [3:0]                  read_index,
	input  logic                        write_enable,
	input  logic [0:0]                  register_index,
	input  logic [4:0]                  write_data,
	input  logic                        done,
	input  logic [2:0]                  status,
	input  logic [fra_pkg::FREQ_W-1:0]  entry_frequency,
	input  logic [fra_pkg::ACC_W-1:0]   entry_run_time,
	input  logic [fra_pkg::ACC_W-1:0]   entry_idle_time,
	input  logic [4:0]                  entries_filled,
	output int                          error_count,
	output int                          pending_count
);
	timeunit 1ns;
	timeprecision 1ps;

	import fra_pkg::*;

	typedef struct {
		status_t           status;
		logic [FREQ_W-1:0] freq;
		logic [ACC_W-1:0]  run;
		logic [ACC_W-1:0]  idle;
		logic [4:0]        filled;
	} residency_result_t;

	residency_result_t expected_results[$];

	logic [FREQ_W-1:0] freq_table [MAX_ENTRIES];
	logic [ACC_W-1:0]  run_us     [MAX_ENTRIES];
	logic [ACC_W-1:0]  idle_us    [MAX_ENTRIES];
	int unsigned       filled_count;
	logic              collect_en;
	logic [4:0]        size_reg;

	function automatic int unsigned live_size();
		return (size_reg < MAX_ENTRIES) ? size_reg : MAX_ENTRIES;
	endfunction

	function automatic logic [ACC_W-1:0] sat_acc(logic [ACC_W-1:0] a, logic [ACC_W-1:0] b);
		logic [ACC_W:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		return sum[ACC_W] ? {ACC_W{1'b1}} : sum[ACC_W-1:0];
	endfunction

	task automatic empty_table();
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			freq_table[i] = '0;
			run_us[i] = '0;
			idle_us[i] = '0;
		end
		filled_count = 0;
	endtask

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		error_count++;
		if (error_count <= 40) begin
			$display("%0t ns: %s mismatch, got %0h, expected %0h", $time, what, got, want);
		end
	endtask

	// Works out the result of one accepted item and updates the mirrored table.
	task automatic predict_residency(logic [1:0] op, logic [FREQ_W-1:0] f,
			logic [TIME_W-1:0] b, logic [TIME_W-1:0] t, logic [CYCLE_W-1:0] c,
			logic [3:0] r);
		residency_result_t res;
		int                hit;
		int unsigned       lim;
		logic [63:0]       span;
		logic [63:0]       run_part;
		logic [63:0]       idle_part;
		res.status = ST_IGNORED;
		res.freq = '0;
		res.run = '0;
		res.idle = '0;
		hit = -1;
		lim = live_size();
		case (op)
			OP_UPDATE: begin
				if (collect_en && lim != 0 && f != 0 && t != 0) begin
					for (int i = 0; i < filled_count && i < lim; i++) begin
						if (hit < 0 && freq_table[i] == f) hit = i;
					end
					if (hit < 0 && filled_count < lim) begin
						hit = filled_count;
						freq_table[hit] = f;
						filled_count++;
					end
					if (hit < 0) begin
						res.status = ST_FULL;
					end else begin
						span = 64'(c) * 64'd1000;
						run_part = (64'(b) * span) / 64'(t);
						if (run_part > span) run_part = span;
						idle_part = span - run_part;
						run_us[hit] = sat_acc(run_us[hit], run_part[ACC_W-1:0]);
						idle_us[hit] = sat_acc(idle_us[hit], idle_part[ACC_W-1:0]);
						res.status = ST_OK;
						res.freq = freq_table[hit];
						res.run = run_us[hit];
						res.idle = idle_us[hit];
					end
				end
			end
			OP_READ: begin
				if (!(collect_en && lim != 0)) begin
					res.status = ST_DISABLED;
				end else if (r >= lim) begin
					res.status = ST_BAD_INDEX;
				end else begin
					res.status = ST_OK;
					res.freq = freq_table[r];
					res.run = run_us[r];
					res.idle = idle_us[r];
				end
			end
			OP_CLEAR: begin
				empty_table();
				res.status = ST_OK;
			end
			default: res.status = ST_IGNORED;
		endcase
		res.filled = filled_count[4:0];
		expected_results.push_back(res);
	endtask

	task automatic check_result();
		residency_result_t want;
		if (expected_results.size() == 0) begin
			report_mismatch("result with no item outstanding, status", 64'(status), 64'd0);
		end else begin
			want = expected_results.pop_front();
			if (status !== want.status)
				report_mismatch("status", 64'(status), 64'(want.status));
			if (entry_frequency !== want.freq)
				report_mismatch("entry_frequency", 64'(entry_frequency), 64'(want.freq));
			if (entry_run_time !== want.run)
				report_mismatch("entry_run_time", 64'(entry_run_time), 64'(want.run));
			if (entry_idle_time !== want.idle)
				report_mismatch("entry_idle_time", 64'(entry_idle_time), 64'(want.idle));
			if (entries_filled !== want.filled)
				report_mismatch("entries_filled", 64'(entries_filled), 64'(want.filled));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			collect_en = 1'b0;
			size_reg = '0;
			empty_table();
			expected_results.delete();
		end else begin
			if (done) check_result();
			if (write_enable) begin
				if (register_index == REG_ENABLE) begin
					collect_en = write_data[0];
					if (!write_data[0]) empty_table();
				end else begin
					size_reg = write_data;
				end
			end
			if (start && !busy) begin
				predict_residency(operation, frequency, busy_ticks, total_ticks,
					cycle_length_ms, read_index);
			end
		end
		pending_count = expected_results.size();
	end

endmodule

### test/freq_residency_accumulator_unit_tb.sv
// Testbench top for freq_residency_accumulator_unit: clock, reset, register
// writes and item stimulus. Depends on fra_pkg, the unit and fra_residency_checker.
module freq_residency_accumulator_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fra_pkg::*;

	// The stall limit lies far above the slowest item, a full-table update, and
	// above the longest sender gap, so it leaves a wide margin.
	localparam int STALL_LIMIT  = 5000;
	localparam int TAIL_CYCLES  = 2 * MAX_ENTRIES + 8;
	localparam int PHASES       = 10;
	localparam int PHASE_ITEMS  = 160;
	localparam int POOL_DEPTH   = 24;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [1:0]         operation = '0;
	logic [FREQ_W-1:0]  frequency = '0;
	logic [TIME_W-1:0]  busy_ticks = '0;
	logic [TIME_W-1:0]  total_ticks = '0;
	logic [CYCLE_W-1:0] cycle_length_ms = '0;
	logic [3:0]         read_index = '0;
	logic               write_enable = 1'b0;
	logic [0:0]         register_index = '0;
	logic [4:0]         write_data = '0;
	logic               done;
	logic [2:0]         status;
	logic [FREQ_W-1:0]  entry_frequency;
	logic [ACC_W-1:0]   entry_run_time;
	logic [ACC_W-1:0]   entry_idle_time;
	logic [4:0]         entries_filled;

	int error_count;
	int pending_count;
	int stall_cycles = 0;

	// Stimulus state: the frequencies used in the current phase, the size
	// that the table currently has in effect, and whether gaps are suppressed.
	logic [FREQ_W-1:0] freq_pool [POOL_DEPTH];
	int                pool_n;
	int                live_entries;
	bit                steady;

	always #5 clk = ~clk;

	freq_residency_accumulator_unit DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.operation       (operation),
		.frequency       (frequency),
		.busy_ticks      (busy_ticks),
		.total_ticks     (total_ticks),
		.cycle_length_ms (cycle_length_ms),
		.read_index      (read_index),
		.write_enable    (write_enable),
		.register_index  (register_index),
		.write_data      (write_data),
		.done            (done),
		.status          (status),
		.entry_frequency (entry_frequency),
		.entry_run_time  (entry_run_time),
		.entry_idle_time (entry_idle_time),
		.entries_filled  (entries_filled)
	);

	fra_residency_checker residency_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.operation       (operation),
		.frequency       (frequency),
		.busy_ticks      (busy_ticks),
		.total_ticks     (total_ticks),
		.cycle_length_ms (cycle_length_ms),
		.read_index      (read_index),
		.write_enable    (write_enable),
		.register_index  (register_index),
		.write_data      (write_data),
		.done            (done),
		.status          (status),
		.entry_frequency (entry_frequency),
		.entry_run_time  (entry_run_time),
		.entry_idle_time (entry_idle_time),
		.entries_filled  (entries_filled),
		.error_count     (error_count),
		.pending_count   (pending_count)
	);

	// The watchdog restarts whenever an item, a result or a register write
	// moves; a hang anywhere in the block lets it run out.
	always @(posedge clk) begin
		if ((start && !busy) || done || write_enable || !arst_n) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// Presents one item and holds it until the block takes it. Every task
	// below is entered and left right after a rising edge, so each signal gets
	// a single nonblocking assignment per edge. Reading busy directly after
	// the edge sees the value the block had when it made its decision.
	task automatic send_item(logic [1:0] op, logic [FREQ_W-1:0] f, logic [TIME_W-1:0] b,
			logic [TIME_W-1:0] t, logic [CYCLE_W-1:0] c, logic [3:0] r);
		start <= 1'b1;
		operation <= op;
		frequency <= f;
		busy_ticks <= b;
		total_ticks <= t;
		cycle_length_ms <= c;
		read_index <= r;
		do @(posedge clk); while (busy);
	endtask

	// Mostly back-to-back or short gaps, now and then a long pause so that
	// the block drains completely before the next item.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady) return 0;
		if (r < 45) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 20);
		return $urandom_range(40, 200);
	endfunction

	task automatic issue(logic [1:0] op, logic [FREQ_W-1:0] f, logic [TIME_W-1:0] b,
			logic [TIME_W-1:0] t, logic [CYCLE_W-1:0] c, logic [3:0] r);
		int gap;
		send_item(op, f, b, t, c, r);
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stops the sender and waits until every outstanding item has produced
	// its result. The checks are made on the falling edge, where the checker's
	// count and the busy output are settled.
	task automatic drain();
		start <= 1'b0;
		do @(negedge clk); while (pending_count != 0 || busy);
		@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Register writes happen only with the block idle. The table size goes
	// first so that the enable write sees the new size; the enable write
	// carries random junk in its unused data bits.
	task automatic reconfigure(logic en, logic [4:0] size);
		logic [3:0] junk;
		junk = 4'($urandom);
		drain();
		write_enable <= 1'b1;
		register_index <= REG_TABLE_SIZE;
		write_data <= size;
		@(posedge clk);
		register_index <= REG_ENABLE;
		write_data <= {junk, en};
		@(posedge clk);
		write_enable <= 1'b0;
		live_entries = (size > MAX_ENTRIES) ? MAX_ENTRIES : size;
	endtask

	// One random item. Most are well-formed samples drawn from the phase's
	// frequency pool, so the table fills, hits and overflows; reads favor
	// indexes inside the table; a few items are malformed samples, clears
	// and the unused operation code.
	task automatic random_item();
		int                r;
		logic [FREQ_W-1:0] f;
		logic [TIME_W-1:0] b;
		logic [TIME_W-1:0] t;
		logic [CYCLE_W-1:0] c;
		logic [3:0]        idx;
		r = $urandom_range(0, 99);
		f = freq_pool[$urandom_range(0, pool_n - 1)];
		t = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 100000) : $urandom;
		if (t == 0) t = 1;
		b = ($urandom_range(0, 4) != 0) ? $urandom_range(0, t) : $urandom;
		case ($urandom_range(0, 19))
			0, 1:    c = 16'($urandom);
			2:       c = '1;
			default: c = 16'($urandom_range(1, 2000));
		endcase
		idx = 4'($urandom);
		if (r < 60) begin
			issue(OP_UPDATE, f, b, t, c, idx);
		end else if (r < 66) begin
			f = $urandom;
			t = $urandom;
			if (r[0]) f = '0;
			else t = '0;
			issue(OP_UPDATE, f, $urandom, t, 16'($urandom), idx);
		end else if (r < 94) begin
			if (live_entries > 0 && $urandom_range(0, 9) < 7)
				idx = 4'($urandom_range(0, live_entries - 1));
			issue(OP_READ, $urandom, $urandom, $urandom, 16'($urandom), idx);
		end else if (r < 97) begin
			issue(OP_CLEAR, $urandom, $urandom, $urandom, 16'($urandom), idx);
		end else begin
			issue(2'd3, f, b, t, c, idx);
		end
	endtask

	initial begin
		logic en;
		logic [4:0] size;
		live_entries = 0;
		steady = 1'b0;

		// Reset is applied once, at the start of the run.
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Straight out of reset the block is disabled with a zero table size:
		// samples are ignored, reads report disabled, clear still works and
		// the unused operation code counts as an ignored sample.
		issue(OP_UPDATE, 32'd1000, 32'd5, 32'd10, 16'd10, 4'd0);
		issue(OP_READ, '0, '0, '0, '0, 4'd0);
		issue(2'd3, 32'd1000, 32'd5, 32'd10, 16'd10, 4'd0);
		issue(OP_CLEAR, '0, '0, '0, '0, 4'd0);

		// Enabled but with a zero table size is still not effectively enabled.
		reconfigure(1'b1, 5'd0);
		issue(OP_UPDATE, 32'd1000, 32'd5, 32'd10, 16'd10, 4'd0);
		issue(OP_READ, '0, '0, '0, '0, 4'd0);

		// A four-entry table: clamping of the run time at the full cycle,
		// zero frequency and zero total ignored, a zero-length cycle, a
		// truncating divide, and a fifth frequency that finds the table full.
		reconfigure(1'b1, 5'd4);
		issue(OP_UPDATE, '1, '1, '1, '1, '1);
		issue(OP_UPDATE, '1, '1, 32'd1, '1, 4'd0);
		issue(OP_UPDATE, '0, 32'd5, 32'd10, 16'd10, 4'd0);
		issue(OP_UPDATE, 32'd1, 32'd5, '0, 16'd10, 4'd0);
		issue(OP_UPDATE, 32'd1, '0, 32'd1, '0, 4'd0);
		issue(OP_UPDATE, 32'h5555_AAAA, 32'd1, 32'd3, 16'd1, 4'h5);
		issue(OP_UPDATE, 32'hAAAA_5555, 32'd2, 32'd3, 16'd7, 4'hA);
		issue(OP_UPDATE, 32'd123456, 32'd1, 32'd2, 16'd100, 4'd0);
		issue(OP_READ, '0, '0, '0, '0, 4'd0);
		issue(OP_READ, '0, '0, '0, '0, 4'd3);
		issue(OP_READ, '0, '0, '0, '0, 4'd4);
		issue(OP_READ, '0, '0, '0, '0, 4'd15);

		// Shrinking the table hides the upper entries: they are neither read
		// nor searched, and nothing new fits while the fill count is too high.
		reconfigure(1'b1, 5'd2);
		issue(OP_READ, '0, '0, '0, '0, 4'd3);
		issue(OP_UPDATE, 32'hAAAA_5555, 32'd1, 32'd4, 16'd8, 4'd0);
		issue(OP_UPDATE, 32'd1, 32'd3, 32'd4, 16'd8, 4'd0);

		// A size above the table depth is capped; a filled entry beyond the
		// shrunk size becomes visible again, an unfilled one reads as zeros.
		reconfigure(1'b1, 5'd31);
		issue(OP_READ, '0, '0, '0, '0, 4'd15);
		issue(OP_UPDATE, 32'hAAAA_5555, 32'd1, 32'd4, 16'd8, 4'd0);
		issue(OP_CLEAR, '1, '1, '1, '1, '1);
		issue(OP_READ, '0, '0, '0, '0, 4'd2);

		// Writing enable low empties the table as well as disabling it.
		reconfigure(1'b1, 5'd16);
		issue(OP_UPDATE, 32'd77, 32'd1, 32'd2, 16'd10, 4'd0);
		reconfigure(1'b0, 5'd16);
		issue(OP_READ, '0, '0, '0, '0, 4'd0);
		reconfigure(1'b1, 5'd16);
		issue(OP_READ, '0, '0, '0, '0, 4'd0);

		// Random phases. Each starts from an idle block, which is also where
		// the sender waits for every outstanding result. The first phases
		// cover the extreme settings; later ones pick sizes at random and keep
		// the table contents when enable stays high.
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0:       begin en = 1'b1; size = 5'd16; end
				1:       begin en = 1'b1; size = 5'd1; end
				2:       begin en = 1'b1; size = 5'd31; end
				3:       begin en = 1'b0; size = 5'($urandom); end
				4:       begin en = 1'b1; size = 5'd0; end
				default: begin
					en = ($urandom_range(0, 9) != 0);
					size = 5'($urandom_range(1, 31));
				end
			endcase
			reconfigure(en, size);
			steady = (p % 3 == 1);
			pool_n = $urandom_range(1, POOL_DEPTH);
			for (int i = 0; i < POOL_DEPTH; i++) begin
				freq_pool[i] = $urandom;
				if (freq_pool[i] == 0) freq_pool[i] = 1;
			end
			if (p % 2 == 0) freq_pool[0] = '1;
			if (pool_n > 1) freq_pool[1] = 32'd1;
			for (int n = 0; n < PHASE_ITEMS; n++) random_item();
		end

		// Let the last results arrive, then give the block time to show any
		// stray result before the verdict.
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0 && pending_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
